FILE: sv/rtc_calendar_with_event_flags_assert.svh
// Assertion macros shared by the calendar checker.
`ifndef RTC_CALENDAR_WITH_EVENT_FLAGS_ASSERT_SVH
`define RTC_CALENDAR_WITH_EVENT_FLAGS_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define RTCCAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RTCCAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RTCCAL_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rtccal_pkg.sv
package rtccal_pkg;

  // Number of listener slots; slot ids at or above this are ignored.
  localparam int LISTENER_SLOTS = 8;

  // Slot code returned when no slot was granted.
  localparam logic [3:0] NO_SLOT = 4'd8;

  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // Highest values a time field may take.
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [4:0] DAY_LAST   = 5'd30;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  // Reset calendar: 12:00:00 on the first of September, year offset 6.
  localparam logic [4:0] HOUR_RESET  = 5'd12;
  localparam logic [3:0] MONTH_RESET = 4'd8;
  localparam logic [7:0] YEAR_RESET  = 8'd6;

  localparam logic [3:0] FEBRUARY = 4'd1;

  localparam logic [4:0] DAYS_IN_MONTH [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    FN_TICK       = 3'd0,
    FN_WRITE      = 3'd1,
    FN_REGISTER   = 3'd2,
    FN_UNREGISTER = 3'd3,
    FN_POLL       = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    FS_SEC   = 3'd0,
    FS_MIN   = 3'd1,
    FS_HOUR  = 3'd2,
    FS_DAY   = 3'd3,
    FS_MONTH = 3'd4,
    FS_YEAR  = 3'd5
  } field_t;

  // Input word layout, lowest field in the lowest bits.
  typedef struct packed {
    logic       pad;
    logic [3:0] listener_id;
    logic [7:0] write_value;
    logic [2:0] field_sel;
  } in_word_t;

  // Result word layout, lowest field in the lowest bits.
  typedef struct packed {
    logic [6:0] pad;
    logic       write_ok;
    logic       event_seen;
    logic [3:0] granted_slot;
    logic       is_leap;
    logic [7:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_day;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_second;
  } out_word_t;

  function automatic logic leap_year(input logic [7:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  // Days in the zero-based month; February gains a day in leap years.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = (month <= MONTH_LAST) ? DAYS_IN_MONTH[month] : 5'd31;
    if (month == FEBRUARY && leap) begin
      len = len + 5'd1;
    end
    return len;
  endfunction

endpackage

FILE: sv/rtc_calendar_with_event_flags.sv
// Real-time calendar with listener event flags. Each input word carries an
// operation in in_tuser: a seconds tick (advances second, minute, hour,
// zero-based day, zero-based month and an 8-bit year offset that wraps, and
// raises every listener's event flag), a write of one time field (taken only
// when the value is in range), a listener register (lowest free slot), a
// listener release, or a poll that reports and clears one listener's flag.
// Every input word yields exactly one result word carrying the calendar after
// that operation plus the grant, poll and write status. The block takes one
// word per cycle: a word is captured in the input register, is evaluated
// against the calendar and slot registers in a single pass of carry-chain and
// priority-encode logic, and lands in the result register, which drives
// out_tvalid. Throughput drops only while the result register is stalled by
// out_tready. After reset the calendar reads 12:00:00, day 0 of month 8
// (September), year offset 6, with no listeners.
module rtc_calendar_with_event_flags (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: field_sel[2:0], write_value[10:3], listener_id[14:11],
  // zero fill at bit 15.
  input  logic [rtccal_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: func[2:0].
  input  logic [rtccal_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: cur_second[5:0], cur_minute[11:6], cur_hour[16:12],
  // cur_day[21:17], cur_month[25:22], cur_year[33:26], is_leap[34],
  // granted_slot[38:35], event_seen[39], write_ok[40], zero fill [47:41].
  output logic [rtccal_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import rtccal_pkg::*;

  // Input register stage.
  logic     in_valid_r;
  func_t    in_func_r;
  in_word_t in_word_r;

  // Result register stage.
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t out_word_nxt;

  // Calendar and listener state.
  logic [5:0] sec_r,   sec_nxt;
  logic [5:0] min_r,   min_nxt;
  logic [4:0] hour_r,  hour_nxt;
  logic [4:0] day_r,   day_nxt;
  logic [3:0] month_r, month_nxt;
  logic [7:0] year_r,  year_nxt;
  logic [LISTENER_SLOTS-1:0] flags_r, flags_nxt;
  logic [LISTENER_SLOTS-1:0] used_r,  used_nxt;

  logic       process;
  logic [4:0] cur_len;
  logic [5:0] day_inc;
  logic [LISTENER_SLOTS-1:0] id_mask;
  logic [LISTENER_SLOTS-1:0] free_onehot;
  logic       free_found;
  logic [3:0] free_idx;
  logic [3:0] granted;
  logic       seen;
  logic       ok;

  // The word in the input register moves on whenever the result register is
  // empty or being drained this cycle.
  assign process   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || process;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  assign cur_len = month_len(month_r, leap_year(year_r));
  assign day_inc = {1'b0, day_r} + 6'd1;

  // Slot decode for release and poll; ids past the last slot match nothing.
  always_comb begin
    for (int i = 0; i < LISTENER_SLOTS; i++) begin
      id_mask[i] = (in_word_r.listener_id == 4'(i));
    end
  end

  // Lowest free slot. Scanning from the top lets the lowest one win.
  always_comb begin
    free_found  = 1'b0;
    free_idx    = NO_SLOT;
    free_onehot = '0;
    for (int i = LISTENER_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found  = 1'b1;
        free_idx    = 4'(i);
        free_onehot = LISTENER_SLOTS'(1) << i;
      end
    end
  end

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    flags_nxt = flags_r;
    used_nxt  = used_r;
    granted   = NO_SLOT;
    seen      = 1'b0;
    ok        = 1'b0;

    unique case (in_func_r)
      FN_TICK: begin
        flags_nxt = '1;
        // Carry chain: each field rolls over only when the one below wraps.
        if (sec_r < SEC_LAST) begin
          sec_nxt = sec_r + 6'd1;
        end else begin
          sec_nxt = '0;
          if (min_r < MIN_LAST) begin
            min_nxt = min_r + 6'd1;
          end else begin
            min_nxt = '0;
            if (hour_r < HOUR_LAST) begin
              hour_nxt = hour_r + 5'd1;
            end else begin
              hour_nxt = '0;
              // A day written past a short month's end rolls over here too.
              if (day_inc < {1'b0, cur_len}) begin
                day_nxt = day_inc[4:0];
              end else begin
                day_nxt = '0;
                if (month_r < MONTH_LAST) begin
                  month_nxt = month_r + 4'd1;
                end else begin
                  month_nxt = '0;
                  year_nxt  = year_r + 8'd1;
                end
              end
            end
          end
        end
      end
      FN_WRITE: begin
        unique case (field_t'(in_word_r.field_sel))
          FS_SEC: begin
            if (in_word_r.write_value <= {2'b00, SEC_LAST}) begin
              sec_nxt = in_word_r.write_value[5:0];
              ok      = 1'b1;
            end
          end
          FS_MIN: begin
            if (in_word_r.write_value <= {2'b00, MIN_LAST}) begin
              min_nxt = in_word_r.write_value[5:0];
              ok      = 1'b1;
            end
          end
          FS_HOUR: begin
            if (in_word_r.write_value <= {3'b000, HOUR_LAST}) begin
              hour_nxt = in_word_r.write_value[4:0];
              ok       = 1'b1;
            end
          end
          FS_DAY: begin
            if (in_word_r.write_value <= {3'b000, DAY_LAST}) begin
              day_nxt = in_word_r.write_value[4:0];
              ok      = 1'b1;
            end
          end
          FS_MONTH: begin
            if (in_word_r.write_value <= {4'b0000, MONTH_LAST}) begin
              month_nxt = in_word_r.write_value[3:0];
              ok        = 1'b1;
            end
          end
          FS_YEAR: begin
            year_nxt = in_word_r.write_value;
            ok       = 1'b1;
          end
          default: begin
          end
        endcase
      end
      FN_REGISTER: begin
        // A fresh listener starts with its flag clear.
        if (free_found) begin
          used_nxt  = used_r | free_onehot;
          flags_nxt = flags_r & ~free_onehot;
          granted   = free_idx;
        end
      end
      FN_UNREGISTER: begin
        used_nxt = used_r & ~id_mask;
      end
      FN_POLL: begin
        // Polling a released slot still reports and clears its flag.
        if ((flags_r & id_mask) != '0) begin
          flags_nxt = flags_r & ~id_mask;
          seen      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.cur_second   = sec_nxt;
    out_word_nxt.cur_minute   = min_nxt;
    out_word_nxt.cur_hour     = hour_nxt;
    out_word_nxt.cur_day      = day_nxt;
    out_word_nxt.cur_month    = month_nxt;
    out_word_nxt.cur_year     = year_nxt;
    out_word_nxt.is_leap      = leap_year(year_nxt);
    out_word_nxt.granted_slot = granted;
    out_word_nxt.event_seen   = seen;
    out_word_nxt.write_ok     = ok;
  end

  // Handshake and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= HOUR_RESET;
      day_r       <= '0;
      month_r     <= MONTH_RESET;
      year_r      <= YEAR_RESET;
      flags_r     <= '0;
      used_r      <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (process) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (process) begin
        sec_r   <= sec_nxt;
        min_r   <= min_nxt;
        hour_r  <= hour_nxt;
        day_r   <= day_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
        flags_r <= flags_nxt;
        used_r  <= used_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_func_r <= func_t'(in_tuser);
      in_word_r <= in_word_t'(in_tdata);
    end
    if (process) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

FILE: sv/rtccal_checker.sv
`include "rtc_calendar_with_event_flags_assert.svh"

module rtccal_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rtccal_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import rtccal_pkg::*;

  out_word_t w;
  logic      idle_now;
  logic      stalled;
  logic      ranges_ok;
  logic      status_ok;

  assign w        = out_word_t'(out_tdata);
  assign idle_now = !out_tvalid && in_tready;
  assign stalled  = out_tvalid && !out_tready;

  assign ranges_ok = (w.cur_second <= SEC_LAST) && (w.cur_minute <= MIN_LAST) &&
                     (w.cur_hour <= HOUR_LAST) && (w.cur_day <= DAY_LAST) &&
                     (w.cur_month <= MONTH_LAST) &&
                     (w.is_leap == (w.cur_year[1:0] == 2'b00));

  assign status_ok = (w.granted_slot <= NO_SLOT) && !(w.event_seen && w.write_ok) &&
                     ((w.granted_slot == NO_SLOT) || (!w.event_seen && !w.write_ok)) &&
                     (w.pad == '0);

  // Reset empties both stages, so the result side is idle and input is open.
  `RTCCAL_ASSERT_NXT_ALWAYS(a_reset_idle, clk, !rst_n, idle_now, "not idle after reset")

  // A stalled result word stays put.
  `RTCCAL_ASSERT_NXT(a_stall_hold, clk, rst_n, stalled, out_tvalid && $stable(out_tdata), "word lost")

  // The calendar never leaves its legal ranges.
  `RTCCAL_ASSERT_IMP(a_ranges, clk, rst_n, out_tvalid, ranges_ok, "calendar out of range")

  // Only one kind of status is reported per word, the granted slot is a slot or NO_SLOT, and the fill bits are zero.
  `RTCCAL_ASSERT_IMP(a_status, clk, rst_n, out_tvalid, status_ok, "inconsistent status")

endmodule

bind rtc_calendar_with_event_flags rtccal_checker u_rtccal_checker (.*);
